[hdl/ftlwl_pkg.sv]
// Shared widths and constants of the wear-levelling block mapper.
package ftlwl_pkg;

    // Fixed field widths of the request, response and configuration ports
    localparam int LBA_W      = 8;
    localparam int PHYS_W     = 9;
    localparam int WEAR_OUT_W = 8;
    localparam int DEAD_W     = 10;
    localparam int CFG_W      = 8;

    // Lifespan after reset
    localparam logic [CFG_W-1:0] LIFESPAN_RESET = 8'd5;

endpackage

[hdl/ftlwl_in_if.sv]
// Request channel: one logical block write per transaction.
interface ftlwl_in_if import ftlwl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LBA_W-1:0] logical_block;

    modport source (output valid, output logical_block, input ready);
    modport sink   (input valid, input logical_block, output ready);
endinterface

[hdl/ftlwl_out_if.sv]
// Response channel: one mapping result per transaction.
interface ftlwl_out_if import ftlwl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PHYS_W-1:0]     physical_block;
    logic                  no_healthy_block;
    logic                  stale_valid;
    logic [PHYS_W-1:0]     stale_block;
    logic [WEAR_OUT_W-1:0] new_wear;
    logic [DEAD_W-1:0]     dead_total;

    modport source (output valid, output physical_block, output no_healthy_block,
                    output stale_valid, output stale_block, output new_wear,
                    output dead_total, input ready);
    modport sink   (input valid, input physical_block, input no_healthy_block,
                    input stale_valid, input stale_block, input new_wear,
                    input dead_total, output ready);
endinterface

[hdl/ftl_wear_leveling_mapper_top.sv]
// Wear-levelling mapper: least-worn healthy block search and map update.
//
//  channel   direction  handshake        payload
//  i_req     in         valid / ready    logical_block
//  o_rsp     out        valid / ready    physical_block, no_healthy_block, stale_valid,
//                                        stale_block, new_wear, dead_total
//  i_cfg     in         i_cfg_we         i_cfg_wdata (lifespan)
//
// A transaction is accepted, then the wear RAM read port delivers one wear entry per cycle
// to the minimum search, then the update writes back the chosen block's wear and map
// entries.
// After reset a clearing pass zeroes the wear and map RAMs; no request is taken meanwhile,
// configuration writes are.
// A request is taken while a previous response still waits; the update cycle holds
// until the response register is free. Out-of-range logical blocks are dropped.
module ftl_wear_leveling_mapper_top import ftlwl_pkg::*; #(
    parameter int PHYS_BLOCKS    = 512,
    parameter int LOGICAL_BLOCKS = 256,
    parameter int WEAR_BITS      = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    ftlwl_in_if.sink         i_req,
    ftlwl_out_if.source      o_rsp
);

    localparam int PB_AW     = $clog2(PHYS_BLOCKS);
    localparam int LB_AW     = LOGICAL_BLOCKS > 1 ? $clog2(LOGICAL_BLOCKS) : 1;
    localparam int LBA_EXT_W = LB_AW > LBA_W ? LB_AW : LBA_W;
    localparam int CLR_DEPTH = PHYS_BLOCKS > LOGICAL_BLOCKS ? PHYS_BLOCKS : LOGICAL_BLOCKS;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);
    localparam int DC_W      = $clog2(PHYS_BLOCKS + 1);
    localparam int WRAM_W    = WEAR_BITS + 1;
    localparam int MRAM_W    = PB_AW + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [CLR_AW-1:0]     r_clr_addr;
    logic [PB_AW-1:0]      r_addr;
    logic                  r_found;
    logic [PB_AW-1:0]      r_best;
    logic [WEAR_BITS-1:0]  r_best_wear;
    logic [LB_AW-1:0]      r_lba;
    logic [CFG_W-1:0]      r_lifespan;
    logic [DC_W-1:0]       r_dead_cnt;

    logic                  r_out_vld;
    logic [PHYS_W-1:0]     r_out_phys;
    logic                  r_out_err;
    logic                  r_out_stale_vld;
    logic [PHYS_W-1:0]     r_out_stale;
    logic [WEAR_OUT_W-1:0] r_out_wear;
    logic [DEAD_W-1:0]     r_out_dead;

    logic                  wram_we;
    logic [PB_AW-1:0]      wram_waddr;
    logic [WRAM_W-1:0]     wram_wdata;
    logic                  wram_re;
    logic [PB_AW-1:0]      wram_raddr;
    logic [WRAM_W-1:0]     wram_rdata;

    logic                  mram_we;
    logic [LB_AW-1:0]      mram_waddr;
    logic [MRAM_W-1:0]     mram_wdata;
    logic [LB_AW-1:0]      mram_raddr;
    logic [MRAM_W-1:0]     mram_rdata;

    logic                  accept;
    logic [LBA_EXT_W-1:0]  lba_ext;
    logic                  lba_in_range;
    logic                  out_free;
    logic                  scan_take;
    logic                  scan_last;
    logic                  commit;
    logic [WEAR_BITS-1:0]  n_wear;
    logic                  n_dead;
    logic [DC_W-1:0]       n_dead_cnt;

    // Request handshake and address decode
    assign i_req.ready  = (r_state == S_IDLE);
    assign accept       = i_req.valid && i_req.ready;
    assign lba_ext      = LBA_EXT_W'(i_req.logical_block);
    assign lba_in_range = lba_ext < LOGICAL_BLOCKS;
    assign out_free     = !r_out_vld || o_rsp.ready;

    // Minimum search over the wear entry read last cycle
    assign scan_take = !wram_rdata[WEAR_BITS] &&
                       (!r_found || (wram_rdata[WEAR_BITS-1:0] < r_best_wear));
    assign scan_last = (r_addr == PB_AW'(PHYS_BLOCKS - 1));

    // Saturating wear increment and death test of the chosen block
    assign n_wear     = (r_best_wear == {WEAR_BITS{1'b1}}) ? r_best_wear
                                                           : r_best_wear + 1'b1;
    assign n_dead     = n_wear >= r_lifespan;
    assign n_dead_cnt = r_dead_cnt + DC_W'(n_dead);
    assign commit     = (r_state == S_DONE) && out_free && r_found;

    // Wear RAM port control: clearing pass, scan reads, write-back
    always_comb begin
        wram_we    = 1'b0;
        wram_waddr = r_best;
        wram_wdata = {n_dead, n_wear};
        if (r_state == S_CLEAR) begin
            wram_we    = r_clr_addr < PHYS_BLOCKS;
            wram_waddr = r_clr_addr[PB_AW-1:0];
            wram_wdata = '0;
        end else if (commit) begin
            wram_we = 1'b1;
        end
        wram_re    = (accept && lba_in_range) || ((r_state == S_SCAN) && !scan_last);
        wram_raddr = accept ? '0 : r_addr + 1'b1;
    end

    // Map RAM port control: clearing pass, lookup on accept, write-back
    always_comb begin
        mram_we    = 1'b0;
        mram_waddr = r_lba;
        mram_wdata = {1'b1, r_best};
        if (r_state == S_CLEAR) begin
            mram_we    = r_clr_addr < LOGICAL_BLOCKS;
            mram_waddr = r_clr_addr[LB_AW-1:0];
            mram_wdata = '0;
        end else if (commit) begin
            mram_we = 1'b1;
        end
        mram_raddr = lba_ext[LB_AW-1:0];
    end

    // Wear entries: dead flag over wear count
    ftlwl_ram #(
        .WIDTH (WRAM_W),
        .DEPTH (PHYS_BLOCKS)
    ) u_wear_ram (
        .i_clk   (i_clk),
        .i_we    (wram_we),
        .i_waddr (wram_waddr),
        .i_wdata (wram_wdata),
        .i_re    (wram_re),
        .i_raddr (wram_raddr),
        .o_rdata (wram_rdata)
    );

    // Map entries: valid bit over physical block
    ftlwl_ram #(
        .WIDTH (MRAM_W),
        .DEPTH (LOGICAL_BLOCKS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (mram_we),
        .i_waddr (mram_waddr),
        .i_wdata (mram_wdata),
        .i_re    (accept && lba_in_range),
        .i_raddr (mram_raddr),
        .o_rdata (mram_rdata)
    );

    // Sequencer, configuration and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_lifespan <= LIFESPAN_RESET;
            r_dead_cnt <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lifespan <= i_cfg_wdata;
            end
            // Drop the response once taken, unless a new one is loaded
            if (r_out_vld && o_rsp.ready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == CLR_AW'(CLR_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    // Latch the address and start the scan; drop out-of-range writes
                    if (accept && lba_in_range) begin
                        r_lba   <= lba_ext[LB_AW-1:0];
                        r_addr  <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_take) begin
                        r_found     <= 1'b1;
                        r_best      <= r_addr;
                        r_best_wear <= wram_rdata[WEAR_BITS-1:0];
                    end
                    if (scan_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_DONE: begin
                    // Hold until the response register is free
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_out_err <= !r_found;
                        if (r_found) begin
                            r_dead_cnt      <= n_dead_cnt;
                            r_out_phys      <= PHYS_W'(r_best);
                            r_out_stale_vld <= mram_rdata[PB_AW];
                            r_out_stale     <= mram_rdata[PB_AW] ?
                                               PHYS_W'(mram_rdata[PB_AW-1:0]) : '0;
                            r_out_wear      <= WEAR_OUT_W'(n_wear);
                            r_out_dead      <= DEAD_W'(n_dead_cnt);
                        end else begin
                            r_out_phys      <= '0;
                            r_out_stale_vld <= 1'b0;
                            r_out_stale     <= '0;
                            r_out_wear      <= '0;
                            r_out_dead      <= DEAD_W'(r_dead_cnt);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    // Drive the response channel
    assign o_rsp.valid            = r_out_vld;
    assign o_rsp.physical_block   = r_out_phys;
    assign o_rsp.no_healthy_block = r_out_err;
    assign o_rsp.stale_valid      = r_out_stale_vld;
    assign o_rsp.stale_block      = r_out_stale;
    assign o_rsp.new_wear         = r_out_wear;
    assign o_rsp.dead_total       = r_out_dead;

    // The RAMs are never written while the scan reads them
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (!wram_we && !mram_we))
        else $error("RAM write during scan");

    // The dead count never passes the number of physical blocks
    a_dead_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dead_cnt <= PHYS_BLOCKS)
        else $error("dead count out of range");

    // The dead count rises by at most one per transaction
    a_dead_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_dead_cnt == $past(r_dead_cnt)) ||
                            (r_dead_cnt == $past(r_dead_cnt) + 1'b1)))
        else $error("dead count jumped");

    // An error response carries no block and changes no state
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free && !r_found) |=>
            (r_out_phys == '0 && r_out_wear == '0 && !r_out_stale_vld &&
             $stable(r_dead_cnt)))
        else $error("error response not clean");

    // No request is taken during the clearing pass
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_req.ready)
        else $error("request taken while clearing");

endmodule

[hdl/ftlwl_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered data.
module ftlwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
